FILE: design/i2f_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2f_pkg
// Shared types and constants for the integer to float converter.
// ----------------------------------------------------------------------------
package i2f_pkg;

   localparam int INT_WIDTH_DEFAULT = 128;
   localparam int CNT_W = 8;   // holds 0..128
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      FMT_SINGLE   = 2'd0,
      FMT_DOUBLE   = 2'd1,
      FMT_EXTENDED = 2'd2,
      FMT_QUAD     = 2'd3
   } fmt_type;

   // front to back: normalized magnitude and classification
   typedef struct packed {
      logic [127:0]      mant;   // leading one at bit 127 (unless zero)
      logic [CNT_W-1:0]  nbits;  // significant bits, 0 means zero input
      logic              neg;
      fmt_type           fmt;
   } norm_type;

   function automatic logic [6:0] fmt_digits(input fmt_type f);
      case (f)
         FMT_SINGLE:   fmt_digits = 7'd24;
         FMT_DOUBLE:   fmt_digits = 7'd53;
         FMT_EXTENDED: fmt_digits = 7'd64;
         default:      fmt_digits = 7'd113;
      endcase
   endfunction

   function automatic logic [14:0] fmt_bias(input fmt_type f);
      case (f)
         FMT_SINGLE:   fmt_bias = 15'd127;
         FMT_DOUBLE:   fmt_bias = 15'd1023;
         default:      fmt_bias = 15'd16383;
      endcase
   endfunction

endpackage
`default_nettype wire

FILE: design/i2f_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2f_front
// Takes the magnitude and normalizes it; registers the result.
// ----------------------------------------------------------------------------
module i2f_front #(
   parameter int INT_WIDTH = i2f_pkg::INT_WIDTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [127:0]      in_value,
   input  wire logic              in_signed,
   input  wire i2f_pkg::fmt_type  in_fmt,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output i2f_pkg::norm_type      out_data
);

   logic [INT_WIDTH-1:0] raw;
   logic [INT_WIDTH-1:0] mag;
   logic [127:0]         mag_ext;
   logic [127:0]         shifted;
   logic [6:0]           lz;
   logic                 found;
   logic                 neg;
   logic                 valid_ff, valid_in;
   i2f_pkg::norm_type    data_ff, data_in;

   assign raw = in_value[INT_WIDTH-1:0];
   assign neg = in_signed & raw[INT_WIDTH-1];
   assign mag = neg ? (~raw + 1'b1) : raw;
   assign mag_ext = 128'(mag);

   // leading zero count: priority search over 128 independent bits
   always_comb begin
      lz = 7'd0;
      found = 1'b0;
      for (int i = 127; i >= 0; i--) begin
         if (!found && mag_ext[i]) begin
            found = 1'b1;
            lz = 7'(127 - i);
         end
      end
   end

   assign shifted = mag_ext << lz;
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in = data_ff;
      if (in_ready) begin
         valid_in = in_valid;
         data_in.mant = shifted;
         data_in.nbits = found ? (8'd128 - {1'b0, lz}) : 8'd0;
         data_in.neg = neg;
         data_in.fmt = in_fmt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule
`default_nettype wire

FILE: design/i2f_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2f_queue
// Small register queue between the front and back stages.
// ----------------------------------------------------------------------------
module i2f_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire i2f_pkg::norm_type  in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output i2f_pkg::norm_type       out_data
);

   localparam int D = i2f_pkg::QUEUE_DEPTH;
   localparam int PW = $clog2(D);

   i2f_pkg::norm_type mem_ff [D];
   logic [PW-1:0] wptr_ff, rptr_ff;
   logic [PW:0]   count_ff;
   logic          wr, rd;

   assign in_ready = count_ff != (PW+1)'(D);
   assign out_valid = count_ff != '0;
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;
   assign out_data = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (wr) wptr_ff <= (wptr_ff == PW'(D-1)) ? '0 : wptr_ff + 1'b1;
         if (rd) rptr_ff <= (rptr_ff == PW'(D-1)) ? '0 : rptr_ff + 1'b1;
         count_ff <= count_ff + (PW+1)'(wr) - (PW+1)'(rd);
      end
      if (wr) mem_ff[wptr_ff] <= in_data;
   end

endmodule
`default_nettype wire

FILE: design/i2f_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2f_back
// Rounds to nearest even, adjusts the exponent and packs the format.
// ----------------------------------------------------------------------------
module i2f_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire i2f_pkg::norm_type  in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic [63:0]             out_low,
   output logic [63:0]             out_high
);

   logic [127:0] m;
   logic [6:0]   md;
   logic [112:0] sig, sig_r;
   logic [113:0] sum;
   logic         rnd, sticky, lsb, carry;
   logic [14:0]  ex;
   logic [63:0]  low_in, high_in;
   logic [63:0]  low_ff, high_ff;
   logic         valid_ff;

   assign m = in_data.mant;
   assign md = i2f_pkg::fmt_digits(in_data.fmt);

   // significand is left aligned: keep top md bits, round on the rest
   always_comb begin
      sig = m[127:15] >> (7'd113 - md);
      rnd = m[7'd127 - md];
      sticky = (m << (md + 8'd1)) != '0;
      lsb = sig[0];
      sum = {1'b0, sig} + {113'd0, (rnd && (sticky || lsb))};
      carry = sum[md];
      sig_r = carry ? sum[113:1] : sum[112:0];
      ex = 15'(in_data.nbits - 8'd1) + {14'd0, carry} + i2f_pkg::fmt_bias(in_data.fmt);
      low_in = '0;
      high_in = '0;
      if (in_data.nbits != '0) begin
         case (in_data.fmt)
            i2f_pkg::FMT_SINGLE: begin
               low_in = {32'd0, in_data.neg, ex[7:0], sig_r[22:0]};
            end
            i2f_pkg::FMT_DOUBLE: begin
               low_in = {in_data.neg, ex[10:0], sig_r[51:0]};
            end
            i2f_pkg::FMT_EXTENDED: begin
               low_in = sig_r[63:0];
               high_in = {48'd0, in_data.neg, ex};
            end
            default: begin
               low_in = sig_r[63:0];
               high_in = {in_data.neg, ex, sig_r[111:64]};
            end
         endcase
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         low_ff <= low_in;
         high_ff <= high_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_low = low_ff;
   assign out_high = high_ff;

endmodule
`default_nettype wire

FILE: design/int128_to_float_convert.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// int128_to_float_convert
// Integer to IEEE-754 float conversion, round to nearest even.
// ----------------------------------------------------------------------------
//  channel  | handshake     | words
//  req      | push / full   | value_low, value_high, signed_input, operation
//  rsp      | pop / empty   | result_low, result_high
//
// One word per cycle sustained while rsp_pop stays high. A word taken on the
// req side passes the front register, the queue and the result register.
// The front normalizes (negate, leading zero count, shift), the back rounds
// and packs. A stalled rsp side fills the result register, the queue and the
// front register, then full rises. Reset is synchronous and empties all stages.
// ----------------------------------------------------------------------------
module int128_to_float_convert #(
   parameter int INT_WIDTH = i2f_pkg::INT_WIDTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [63:0] req_value_low,
   input  wire logic [63:0] req_value_high,
   input  wire logic        req_signed_input,
   input  wire logic [1:0]  req_operation,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [63:0]      rsp_result_low,
   output logic [63:0]      rsp_result_high
);

   logic              f_ready, f_valid, q_ready, q_valid, b_ready, b_valid;
   i2f_pkg::norm_type f_data, q_data;

   i2f_front #(.INT_WIDTH(INT_WIDTH)) u_front (
      .clock, .reset,
      .in_valid(req_push), .in_ready(f_ready),
      .in_value({req_value_high, req_value_low}),
      .in_signed(req_signed_input),
      .in_fmt(i2f_pkg::fmt_type'(req_operation)),
      .out_valid(f_valid), .out_ready(q_ready), .out_data(f_data)
   );

   i2f_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(q_ready), .in_data(f_data),
      .out_valid(q_valid), .out_ready(b_ready), .out_data(q_data)
   );

   i2f_back u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(b_ready), .in_data(q_data),
      .out_valid(b_valid), .out_ready(rsp_pop),
      .out_low(rsp_result_low), .out_high(rsp_result_high)
   );

   assign req_full = !f_ready;
   assign rsp_empty = !b_valid;

endmodule
`default_nettype wire

FILE: design/i2f_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2f_checker
// Port-level checks on the converter.
// ----------------------------------------------------------------------------
module i2f_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_push,
   input wire logic        req_full,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [63:0] rsp_result_low,
   input wire logic [63:0] rsp_result_high
);

   // a waiting word holds until popped
   assert property (@(posedge clock) disable iff (reset)
      $past(!rsp_empty && !rsp_pop) && !$past(reset) |-> !rsp_empty && $stable(rsp_result_low))
      else $error("result word changed while waiting");

   // the rsp side is empty after reset
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result after reset");

   // result register empty at accept: a word reaches the rsp side through the front register and the queue
   assert property (@(posedge clock) disable iff (reset)
      req_push && !req_full && rsp_empty |=> ##2 !rsp_empty)
      else $error("word lost in pipe");

   // after reset the input side is open
   assert property (@(posedge clock) reset |=> !req_full)
      else $error("full after reset");

endmodule

bind int128_to_float_convert i2f_checker u_checker (
   .clock, .reset, .req_push, .req_full, .rsp_empty, .rsp_pop,
   .rsp_result_low, .rsp_result_high
);
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks int128_to_float_convert against a behavioral integer to float
// converter: directed corner values, then random traffic on all formats.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [63:0] req_value_low = '0;
   logic [63:0] req_value_high = '0;
   logic        req_signed_input = 1'b0;
   logic [1:0]  req_operation = i2f_pkg::FMT_SINGLE;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [63:0] rsp_result_low;
   logic [63:0] rsp_result_high;

   logic [127:0] float_queue[$];
   int errors = 0;
   int words_sent = 0;
   int words_checked = 0;
   int cycles = 0;
   bit send_quiet = 1'b0;
   bit pop_quiet = 1'b0;

   int128_to_float_convert u_top (.*);

   always #5 clock = ~clock;

   // expected {high, low} for one conversion, round to nearest even
   function automatic logic [127:0] convert_int(logic [127:0] value, logic is_signed,
                                                i2f_pkg::fmt_type fmt);
      logic [127:0] mag;
      logic         neg;
      int           nbits, digits, sh;
      logic [15:0]  expo;
      logic         rnd, sticky;
      logic [63:0]  lo, hi;
      mag = value;
      neg = is_signed && value[127];
      if (neg) mag = ~value + 128'd1;
      if (mag == 0) return '0;
      nbits = 0;
      for (int i = 0; i < 128; i++) if (mag[i]) nbits = i + 1;
      case (fmt)
         i2f_pkg::FMT_SINGLE:   digits = 24;
         i2f_pkg::FMT_DOUBLE:   digits = 53;
         i2f_pkg::FMT_EXTENDED: digits = 64;
         default:               digits = 113;
      endcase
      expo = 16'(nbits - 1);
      if (nbits > digits) begin
         sh = nbits - digits;
         rnd = mag[sh-1];
         sticky = (sh > 1) && ((mag & ((128'd1 << (sh - 1)) - 128'd1)) != 0);
         mag = mag >> sh;
         if (rnd && (sticky || mag[0])) mag = mag + 128'd1;
         if (mag[digits]) begin
            mag = mag >> 1;
            expo = expo + 16'd1;
         end
      end else begin
         mag = mag << (digits - nbits);
      end
      lo = mag[63:0];
      hi = '0;
      case (fmt)
         i2f_pkg::FMT_SINGLE: begin
            expo = expo + 16'd127;
            lo = {32'd0, neg, expo[7:0], mag[22:0]};
         end
         i2f_pkg::FMT_DOUBLE: begin
            expo = expo + 16'd1023;
            lo = {neg, expo[10:0], mag[51:0]};
         end
         i2f_pkg::FMT_EXTENDED: begin
            expo = expo + 16'd16383;
            hi = {48'd0, neg, expo[14:0]};
         end
         default: begin
            expo = expo + 16'd16383;
            hi = {neg, expo[14:0], mag[111:64]};
         end
      endcase
      return {hi, lo};
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= 20)
         $display("mismatch %s: got %h expected %h (word %0d)", what, got, want,
                  words_checked);
   endtask

   // hold push until the word is taken; push stays up for a following word
   task automatic send_word(logic [127:0] value, logic is_signed, i2f_pkg::fmt_type fmt);
      while (!send_quiet && $urandom_range(99) < 6) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_value_low <= value[63:0];
      req_value_high <= value[127:64];
      req_signed_input <= is_signed;
      req_operation <= fmt;
      do @(posedge clock); while (req_full);
      float_queue.push_back(convert_int(value, is_signed, fmt));
      words_sent++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
         end
         if (rsp_pop && !rsp_empty) begin
            if (float_queue.size() == 0) begin
               report("unexpected word", rsp_result_low, '0);
            end else begin
               logic [127:0] want;
               want = float_queue.pop_front();
               if (rsp_result_low !== want[63:0]) report("low", rsp_result_low, want[63:0]);
               if (rsp_result_high !== want[127:64])
                  report("high", rsp_result_high, want[127:64]);
            end
            words_checked++;
         end
         rsp_pop <= pop_quiet || ($urandom_range(99) >= 6);
      end
   end

   function automatic logic [127:0] rand128();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   task automatic test_corners();
      i2f_pkg::fmt_type fmt;
      for (int f = 0; f < 4; f++) begin
         fmt = i2f_pkg::fmt_type'(f);
         send_word('0, 1'b1, fmt);
         send_word('1, 1'b1, fmt);
         send_word('1, 1'b0, fmt);
         send_word({1'b1, 127'd0}, 1'b1, fmt);
         send_word({1'b0, {127{1'b1}}}, 1'b1, fmt);
         send_word(128'd1, 1'b0, fmt);
      end
      // ties to even and carry out of rounding
      send_word(128'h1000003, 1'b0, i2f_pkg::FMT_SINGLE);
      send_word(128'h1000001, 1'b0, i2f_pkg::FMT_SINGLE);
      send_word(128'h3FFFFFFFFFFFFFFFF, 1'b0, i2f_pkg::FMT_EXTENDED);
   endtask

   task automatic test_random(int count, bit quiet);
      logic [127:0] v;
      int           sh;
      send_quiet = quiet;
      pop_quiet = quiet;
      for (int i = 0; i < count; i++) begin
         v = rand128();
         sh = $urandom_range(127);
         if ($urandom_range(1)) v = v >> sh;   // spread the leading one position
         if ($urandom_range(7) == 0) v = {v[127:64] | 64'hFFFF_FFFF_FFFF_FF00, v[63:0]};
         send_word(v, 1'($urandom), i2f_pkg::fmt_type'($urandom_range(3)));
      end
      send_quiet = 1'b0;
      pop_quiet = 1'b0;
   endtask

   task automatic test_drain_pause();
      req_push <= 1'b0;
      while (float_queue.size() != 0) @(posedge clock);
      test_random(50, 1'b0);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corners();
      test_random(700, 1'b0);
      test_drain_pause();
      test_random(300, 1'b1);
      test_random(650, 1'b0);
      req_push <= 1'b0;
      while (float_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("sent %0d words over all four formats, checked %0d results", words_sent,
               words_checked);
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: files.f
design/i2f_pkg.sv
design/i2f_front.sv
design/i2f_queue.sv
design/i2f_back.sv
design/int128_to_float_convert.sv
design/i2f_checker.sv
test/tb_top.sv
